// ----- rtl/rmat_pkg.sv -----
`timescale 1ns / 1ps
`default_nettype none

package rmat_pkg;

  localparam int LEAVES_DEF = 1024;
  localparam int VAL_W      = 64;
  localparam int POS_W      = 10;
  localparam int RNG_W      = 11;

  typedef logic signed [VAL_W-1:0] val_t;
  typedef logic        [POS_W-1:0] pos_t;
  typedef logic        [RNG_W-1:0] rng_t;

  localparam val_t VAL_MIN = {1'b1, {(VAL_W-1){1'b0}}};

  typedef enum logic [2:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_U_LEAF,
    ST_U_UP,
    ST_Q_WALK,
    ST_Q_DRAIN,
    ST_Q_DONE
  } state_t;

  typedef struct packed {
    logic clear_step;
    logic load;
    logic leaf_write;
    logic up_step;
    logic walk;
    logic load_out;
  } cmd_t;

  typedef struct packed {
    logic clear_last;
    logic op_query;
    logic pos_ok;
    logic root_next;
    logic range_open;
    logic out_space;
  } status_t;

endpackage

`default_nettype wire

// ----- rtl/rmat_ctrl.sv -----
`timescale 1ns / 1ps
`default_nettype none

module rmat_ctrl
  import rmat_pkg::*;
(
  input  wire logic    clk,
  input  wire logic    rst,
  input  wire logic    in_valid,
  output logic         in_ready,
  input  wire status_t status,
  output cmd_t         cmd
);

  state_t state, state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_CLEAR;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    unique case (state)
      ST_CLEAR: begin
        if (status.clear_last) state_next = ST_IDLE;
      end
      ST_IDLE: begin
        if (in_valid) begin
          if (status.op_query) begin
            state_next = ST_Q_WALK;
          end else if (status.pos_ok) begin
            state_next = ST_U_LEAF;
          end
        end
      end
      ST_U_LEAF: begin
        state_next = ST_U_UP;
      end
      ST_U_UP: begin
        if (status.root_next) state_next = ST_IDLE;
      end
      ST_Q_WALK: begin
        if (!status.range_open) state_next = ST_Q_DRAIN;
      end
      ST_Q_DRAIN: begin
        state_next = ST_Q_DONE;
      end
      ST_Q_DONE: begin
        if (status.out_space) state_next = ST_IDLE;
      end
      default: begin
        state_next = ST_CLEAR;
      end
    endcase
  end

  always_comb begin
    cmd      = '0;
    in_ready = 1'b0;
    unique case (state)
      ST_CLEAR: begin
        cmd.clear_step = 1'b1;
      end
      ST_IDLE: begin
        in_ready = 1'b1;
        cmd.load = in_valid;
      end
      ST_U_LEAF: begin
        cmd.leaf_write = 1'b1;
      end
      ST_U_UP: begin
        cmd.up_step = 1'b1;
      end
      ST_Q_WALK: begin
        cmd.walk = 1'b1;
      end
      ST_Q_DRAIN: begin
      end
      ST_Q_DONE: begin
        cmd.load_out = status.out_space;
      end
      default: begin
      end
    endcase
  end

endmodule

`default_nettype wire

// ----- rtl/rmat_datapath.sv -----
`timescale 1ns / 1ps
`default_nettype none

module rmat_datapath
  import rmat_pkg::*;
#(
  parameter int LEAVES = LEAVES_DEF
) (
  input  wire logic clk,
  input  wire logic rst,
  input  wire cmd_t cmd,
  output status_t   status,
  input  wire logic operation,
  input  wire pos_t leaf_position,
  input  wire val_t leaf_value,
  input  wire rng_t range_low,
  input  wire rng_t range_high,
  output val_t      max_value,
  output pos_t      max_position,
  output logic      found,
  output logic      out_valid,
  input  wire logic out_ready
);

  localparam int DEPTH = 2 * LEAVES;
  localparam int IDX_W = $clog2(DEPTH);
  localparam int LR_W  = $clog2(DEPTH + 1);
  localparam int SAT_W = (LR_W > RNG_W) ? LR_W : RNG_W;
  localparam int ACC_W = $clog2(4 * LEAVES) + 1;
  localparam int P2    = 1 << $clog2(LEAVES);

  localparam logic [ACC_W-1:0] TWO_L   = ACC_W'(DEPTH);
  localparam logic [ACC_W-1:0] L_ACC   = ACC_W'(LEAVES);
  localparam logic [ACC_W-1:0] P2_ACC  = ACC_W'(P2);
  localparam logic [SAT_W-1:0] L_SAT   = SAT_W'(LEAVES);
  localparam logic [IDX_W-1:0] L_IDX   = IDX_W'(LEAVES);
  localparam logic [LR_W-1:0]  L_LR    = LR_W'(LEAVES);
  localparam logic [IDX_W-1:0] ROOT    = IDX_W'(1);
  localparam logic [IDX_W-1:0] LAST_N  = IDX_W'(DEPTH - 1);

  // node store: max value and its leaf position
  val_t mem_val [DEPTH];
  pos_t mem_pos [DEPTH];

  logic             we;
  logic [IDX_W-1:0] waddr;
  val_t             wval;
  pos_t             wpos;
  logic [IDX_W-1:0] raddr_a, raddr_b;
  val_t             rd_a_val, rd_b_val;
  pos_t             rd_a_pos, rd_b_pos;

  always_ff @(posedge clk) begin
    if (we) begin
      mem_val[waddr] <= wval;
      mem_pos[waddr] <= wpos;
    end
    rd_a_val <= mem_val[raddr_a];
    rd_a_pos <= mem_pos[raddr_a];
    rd_b_val <= mem_val[raddr_b];
    rd_b_pos <= mem_pos[raddr_b];
  end

  // clearing pass: node n gets the leftmost leaf of its subtree.
  // clr_acc = n * 2^k at the level's shift; halved when it lands past the leaves.
  logic [IDX_W-1:0] clr_n, clr_inc;
  logic [ACC_W-1:0] clr_acc, clr_stride, clr_sum, clr_m;
  logic             clr_pow2;
  pos_t             clr_pos;

  assign clr_inc  = clr_n + IDX_W'(1);
  assign clr_pow2 = ((clr_inc & clr_n) == '0);
  assign clr_sum  = clr_acc + clr_stride;
  assign clr_m    = (clr_acc >= TWO_L) ? (clr_acc >> 1) : clr_acc;
  assign clr_pos  = POS_W'(clr_m - L_ACC);

  always_ff @(posedge clk) begin
    if (rst) begin
      clr_n      <= ROOT;
      clr_acc    <= P2_ACC;
      clr_stride <= P2_ACC;
    end else if (cmd.clear_step) begin
      clr_n <= clr_inc;
      if (clr_pow2 && (clr_sum >= TWO_L)) begin
        clr_acc    <= clr_sum >> 1;
        clr_stride <= clr_stride >> 1;
      end else begin
        clr_acc <= clr_sum;
      end
    end
  end

  // update path: carry the freshly combined node, read only its sibling
  logic [IDX_W-1:0] upd_n, parent;
  val_t             cur_val, comb_val;
  pos_t             cur_pos, comb_pos;
  logic             take_sib;

  assign parent = upd_n >> 1;

  always_comb begin
    if (!upd_n[0]) begin
      take_sib = (rd_a_val > cur_val);
    end else begin
      take_sib = !(cur_val > rd_a_val);
    end
    comb_val = take_sib ? rd_a_val : cur_val;
    comb_pos = take_sib ? rd_a_pos : cur_pos;
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      upd_n   <= IDX_W'(leaf_position) + L_IDX;
      cur_val <= leaf_value;
      cur_pos <= leaf_position;
    end else if (cmd.up_step) begin
      upd_n   <= parent;
      cur_val <= comb_val;
      cur_pos <= comb_pos;
    end
  end

  // query walk
  logic [SAT_W-1:0] lo_ext, hi_ext, lo_sat, hi_sat;
  logic [LR_W-1:0]  ql, qr, ql_adv, qr_dec;
  logic             range_open;

  assign lo_ext     = SAT_W'(range_low);
  assign hi_ext     = SAT_W'(range_high);
  assign lo_sat     = (lo_ext > L_SAT) ? L_SAT : lo_ext;
  assign hi_sat     = (hi_ext > L_SAT) ? L_SAT : hi_ext;
  assign ql_adv     = ql + LR_W'(ql[0]);
  assign qr_dec     = qr - LR_W'(qr[0]);
  assign range_open = (ql < qr);

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      ql <= LR_W'(lo_sat) + L_LR;
      qr <= LR_W'(hi_sat) + L_LR;
    end else if (cmd.walk && range_open) begin
      ql <= ql_adv >> 1;
      qr <= qr_dec >> 1;
    end
  end

  // stage 1: node reads in flight; stage 2: winner of the level's pair
  logic s1_vl, s1_vr, s2_valid;
  val_t s2_val, pair_val, best;
  pos_t s2_pos, pair_pos, best_pos;
  logic pair_r;

  assign pair_r   = s1_vr && (!s1_vl || (rd_b_val > rd_a_val));
  assign pair_val = pair_r ? rd_b_val : rd_a_val;
  assign pair_pos = pair_r ? rd_b_pos : rd_a_pos;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_vl    <= 1'b0;
      s1_vr    <= 1'b0;
      s2_valid <= 1'b0;
    end else begin
      s1_vl    <= cmd.walk && range_open && ql[0];
      s1_vr    <= cmd.walk && range_open && qr[0];
      s2_valid <= s1_vl || s1_vr;
    end
  end

  always_ff @(posedge clk) begin
    s2_val <= pair_val;
    s2_pos <= pair_pos;
    if (cmd.load) begin
      best     <= VAL_MIN;
      best_pos <= '0;
    end else if (s2_valid && (s2_val > best)) begin
      best     <= s2_val;
      best_pos <= s2_pos;
    end
  end

  // memory port steering
  always_comb begin
    we      = 1'b0;
    waddr   = clr_n;
    wval    = '0;
    wpos    = clr_pos;
    raddr_a = IDX_W'(ql);
    raddr_b = IDX_W'(qr_dec);
    if (cmd.clear_step) begin
      we = 1'b1;
    end else if (cmd.leaf_write) begin
      we      = 1'b1;
      waddr   = upd_n;
      wval    = cur_val;
      wpos    = cur_pos;
      raddr_a = {upd_n[IDX_W-1:1], ~upd_n[0]};
    end else if (cmd.up_step) begin
      we      = 1'b1;
      waddr   = parent;
      wval    = comb_val;
      wpos    = comb_pos;
      raddr_a = {parent[IDX_W-1:1], ~parent[0]};
    end
  end

  // result register
  logic best_found;
  assign best_found = (best != VAL_MIN);

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.load_out) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load_out) begin
      max_value    <= best;
      max_position <= best_found ? best_pos : '0;
      found        <= best_found;
    end
  end

  always_comb begin
    status.clear_last = (clr_n == LAST_N);
    status.op_query   = operation;
    status.pos_ok     = (SAT_W'(leaf_position) < L_SAT);
    status.root_next  = (parent == ROOT);
    status.range_open = range_open;
    status.out_space  = !out_valid || out_ready;
  end

  a_load_out_valid : assert property (@(posedge clk) disable iff (rst)
    cmd.load_out |=> out_valid)
    else $error("result load did not raise out_valid");

  a_found_value : assert property (@(posedge clk) disable iff (rst)
    (out_valid && found) |-> (max_value != VAL_MIN))
    else $error("found set with most negative value");

  a_none_fields : assert property (@(posedge clk) disable iff (rst)
    (out_valid && !found) |-> (max_value == VAL_MIN && max_position == '0))
    else $error("empty result carries stale fields");

  a_up_below_root : assert property (@(posedge clk) disable iff (rst)
    cmd.up_step |-> (upd_n > ROOT))
    else $error("ancestor step issued at the root");

endmodule

`default_nettype wire

// ----- rtl/range_max_argmax_tree.sv -----
// Channel  Signals                                     Request
// in       in_valid, in_ready                          operation, leaf_position, leaf_value,
//                                                      range_low, range_high
// out      out_valid, out_ready                        max_value, max_position, found
//
// Update: the leaf is written, then one tree level per cycle up to the root;
//   the node memory is written at the parent and read at its sibling in the same cycle.
// Query: one level per cycle through two read ports, then a pair stage and a fold
//   stage. Updates give no result.
// Reset: a clearing pass writes every node; in_ready stays low.
// A waiting result does not block the next accept; a query only stalls at its end
// while the output register is still full.
`timescale 1ns / 1ps
`default_nettype none

module range_max_argmax_tree
  import rmat_pkg::*;
#(
  parameter int LEAVES = LEAVES_DEF
) (
  input  wire logic clk,
  input  wire logic rst,
  input  wire logic in_valid,
  output logic      in_ready,
  input  wire logic operation,
  input  wire pos_t leaf_position,
  input  wire val_t leaf_value,
  input  wire rng_t range_low,
  input  wire rng_t range_high,
  output logic      out_valid,
  input  wire logic out_ready,
  output val_t      max_value,
  output pos_t      max_position,
  output logic      found
);

  cmd_t    cmd;
  status_t status;

  rmat_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .status   (status),
    .cmd      (cmd)
  );

  rmat_datapath #(
    .LEAVES (LEAVES)
  ) u_datapath (
    .clk           (clk),
    .rst           (rst),
    .cmd           (cmd),
    .status        (status),
    .operation     (operation),
    .leaf_position (leaf_position),
    .leaf_value    (leaf_value),
    .range_low     (range_low),
    .range_high    (range_high),
    .max_value     (max_value),
    .max_position  (max_position),
    .found         (found),
    .out_valid     (out_valid),
    .out_ready     (out_ready)
  );

endmodule

`default_nettype wire
